### src/tbda_pkg.sv
// shared types and constants for the two-button debounce and adjust unit
// no dependencies

package tbda_pkg;

    localparam int PERIOD_MAX_DEF = 10;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd100;
    localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
    localparam logic [7:0]  BL_PERIOD_RST  = 8'd100;
    localparam logic [7:0]  BL_STEP_RST    = 8'd10;

    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_BL_PERIOD  = 2'd2;
    localparam logic [1:0] REG_BL_STEP    = 2'd3;

    typedef struct packed {
        logic minus_level;
        logic plus_level;
        logic period_enable_n;
        logic duty_enable_n;
    } in_item_t;

    typedef struct packed {
        logic [3:0] audio_period;
        logic [7:0] backlight_duty;
        logic       audio_on;
        logic [2:0] fsm_state;
    } out_item_t;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] long_press_ticks;
        logic [7:0]  backlight_period;
        logic [7:0]  backlight_step;
    } cfg_t;

endpackage

### src/two_button_debounce_adjust_unit.sv
// top level: configuration registers, input transfer control, result register
// depends on tbda_pkg and tbda_core
//
// Usage: each transfer on the s_ channel is one tick carrying the minus and
// plus button levels (0 = pressed) and the two active-low enable switches.
// Every input transfer produces exactly one result on the m_ channel: the
// audio period, backlight duty, speaker flag and controller state after
// that tick.
// The result is registered at the edge where the input transfer happens
// and is offered on m_ from the next cycle.
// Throughput is one tick per cycle when unstalled; the update is a single pass
// through the button state machine between the state and result registers.
// s_ready stays high while the result register is empty or is being taken,
// so a stalled receiver holds at most one result and blocks further ticks.
// The cfg channel is always ready; index 0 debounce ticks, 1 long press
// ticks, 2 backlight period, 3 backlight step. Other indexes are ignored.
// Reset (aresetn low, synchronous) returns the controller to idle, the
// period to 1, duty to 0, speaker on, registers to their defaults, and
// empties the result register.

module two_button_debounce_adjust_unit #(
    parameter int PERIOD_MAX = tbda_pkg::PERIOD_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tbda_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tbda_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    tbda_pkg::cfg_t      cfg_reg;
    tbda_pkg::out_item_t result;
    tbda_pkg::out_item_t m_data_reg;
    logic                m_valid_reg;
    logic                s_xfer;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_xfer    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= tbda_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_ticks <= tbda_pkg::LONG_PRESS_RST;
            cfg_reg.backlight_period <= tbda_pkg::BL_PERIOD_RST;
            cfg_reg.backlight_step   <= tbda_pkg::BL_STEP_RST;
        end else if (cfg_valid && cfg_index[7:2] == 6'd0) begin
            unique case (cfg_index[1:0])
                tbda_pkg::REG_DEBOUNCE:   cfg_reg.debounce_ticks   <= cfg_data;
                tbda_pkg::REG_LONG_PRESS: cfg_reg.long_press_ticks <= cfg_data;
                tbda_pkg::REG_BL_PERIOD:  cfg_reg.backlight_period <= cfg_data[7:0];
                tbda_pkg::REG_BL_STEP:    cfg_reg.backlight_step   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    tbda_core #(
        .PERIOD_MAX(PERIOD_MAX)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (s_xfer),
        .item   (s_data),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) m_data_reg <= result;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### src/tbda_core.sv
// button state machine with period, duty and speaker state
// depends on tbda_pkg

module tbda_core #(
    parameter int PERIOD_MAX = tbda_pkg::PERIOD_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  tbda_pkg::in_item_t  item,
    input  tbda_pkg::cfg_t      cfg,
    output tbda_pkg::out_item_t result
);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_MINUS_DEB  = 3'd1;
    localparam logic [2:0] ST_MINUS_ACT  = 3'd2;
    localparam logic [2:0] ST_MINUS_HOLD = 3'd3;
    localparam logic [2:0] ST_REL_DEB    = 3'd4;
    localparam logic [2:0] ST_PLUS_DEB   = 3'd5;
    localparam logic [2:0] ST_PLUS_ACT   = 3'd6;
    localparam logic [2:0] ST_PLUS_HOLD  = 3'd7;

    localparam logic [3:0] PMAX = 4'(PERIOD_MAX);

    logic [2:0]  state_reg, state_next;
    logic [15:0] tick_reg, tick_next;
    logic [3:0]  period_reg, period_next;
    logic [7:0]  duty_reg, duty_next;
    logic        spk_reg, spk_next;

    logic        minus_down, plus_down, per_en, duty_en, restart;
    logic        deb_done, long_done;
    logic [8:0]  duty_sum;

    assign minus_down = !item.minus_level;
    assign plus_down  = !item.plus_level;
    assign per_en     = !item.period_enable_n;
    assign duty_en    = !item.duty_enable_n;
    assign deb_done   = tick_reg >= cfg.debounce_ticks;
    assign long_done  = tick_reg >= cfg.long_press_ticks;
    assign duty_sum   = {1'b0, duty_reg} + {1'b0, cfg.backlight_step};

    always_comb begin
        state_next  = state_reg;
        period_next = period_reg;
        duty_next   = duty_reg;
        spk_next    = spk_reg;
        restart     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (minus_down) begin
                    restart    = 1'b1;
                    state_next = ST_MINUS_DEB;
                end else if (plus_down) begin
                    restart    = 1'b1;
                    state_next = ST_PLUS_DEB;
                end
            end
            ST_MINUS_DEB: begin
                if (deb_done) state_next = minus_down ? ST_MINUS_ACT : ST_IDLE;
            end
            ST_MINUS_ACT: begin
                if (per_en) period_next = (period_reg >= PMAX) ? 4'd1 : period_reg + 4'd1;
                if (duty_en) begin
                    if (duty_reg == 8'd0) duty_next = cfg.backlight_period;
                    else if (duty_reg < cfg.backlight_step) duty_next = 8'd0;
                    else duty_next = duty_reg - cfg.backlight_step;
                end
                state_next = ST_MINUS_HOLD;
            end
            ST_MINUS_HOLD: begin
                if (long_done) begin
                    spk_next = 1'b0;
                    restart  = 1'b1;
                end
                if (!minus_down) begin
                    state_next = ST_REL_DEB;
                    restart    = 1'b1;
                end
            end
            ST_REL_DEB: begin
                if (deb_done) state_next = ST_IDLE;
            end
            ST_PLUS_DEB: begin
                if (deb_done) state_next = plus_down ? ST_PLUS_ACT : ST_IDLE;
            end
            ST_PLUS_ACT: begin
                if (per_en) period_next = (period_reg <= 4'd1) ? PMAX : period_reg - 4'd1;
                if (duty_en) begin
                    if (duty_reg == cfg.backlight_period) duty_next = 8'd0;
                    else if (duty_sum > {1'b0, cfg.backlight_period})
                        duty_next = cfg.backlight_period;
                    else duty_next = duty_sum[7:0];
                end
                state_next = ST_PLUS_HOLD;
            end
            default: begin
                if (long_done) begin
                    spk_next = 1'b1;
                    restart  = 1'b1;
                end
                if (!plus_down) begin
                    state_next = ST_REL_DEB;
                    restart    = 1'b1;
                end
            end
        endcase
        if (restart) tick_next = 16'd0;
        else if (tick_reg != 16'hFFFF) tick_next = tick_reg + 16'd1;
        else tick_next = tick_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tick_reg   <= 16'd0;
            period_reg <= 4'd1;
            duty_reg   <= 8'd0;
            spk_reg    <= 1'b1;
        end else if (step) begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            period_reg <= period_next;
            duty_reg   <= duty_next;
            spk_reg    <= spk_next;
        end
    end

    assign result.audio_period   = period_next;
    assign result.backlight_duty = duty_next;
    assign result.audio_on       = spk_next;
    assign result.fsm_state      = state_next;

endmodule

### tb/tb_two_button_debounce_adjust_unit.sv
// testbench for two_button_debounce_adjust_unit: ticks of button and switch levels,
// results checked against a cycle-free model of the controller held in a scoreboard class
// depends on tbda_pkg and the two_button_debounce_adjust_unit rtl

typedef enum logic [2:0] {
    ST_IDLE, ST_MINUS_DB, ST_MINUS_ACT, ST_MINUS_HOLD,
    ST_RELEASE_DB, ST_PLUS_DB, ST_PLUS_ACT, ST_PLUS_HOLD
} ctrl_state_e;

class adjust_scoreboard;
    tbda_pkg::cfg_t      regs;
    ctrl_state_e         state;
    logic [15:0]         hold_count;
    logic [3:0]          period;
    logic [7:0]          duty;
    logic                speaker;
    tbda_pkg::out_item_t expected_settings [$];
    int                  errors;

    function new();
        regs.debounce_ticks   = tbda_pkg::DEBOUNCE_RST;
        regs.long_press_ticks = tbda_pkg::LONG_PRESS_RST;
        regs.backlight_period = tbda_pkg::BL_PERIOD_RST;
        regs.backlight_step   = tbda_pkg::BL_STEP_RST;
        state      = ST_IDLE;
        hold_count = '0;
        period     = 4'd1;
        duty       = '0;
        speaker    = 1'b1;
        errors     = 0;
    endfunction

    task report(input string msg);
        if (errors < 20) $display("mismatch: %s", msg);
        errors++;
    endtask

    function int pending();
        return expected_settings.size();
    endfunction

    function void write_reg(input logic [7:0] idx, input logic [15:0] data);
        case (idx)
            tbda_pkg::REG_DEBOUNCE:   regs.debounce_ticks   = data;
            tbda_pkg::REG_LONG_PRESS: regs.long_press_ticks = data;
            tbda_pkg::REG_BL_PERIOD:  regs.backlight_period = data[7:0];
            tbda_pkg::REG_BL_STEP:    regs.backlight_step   = data[7:0];
            default: ;
        endcase
    endfunction

    function void step_down(input bit per_en, input bit duty_en);
        if (per_en) period = (period >= tbda_pkg::PERIOD_MAX_DEF) ? 4'd1 : period + 4'd1;
        if (duty_en) begin
            if (duty == 0) duty = regs.backlight_period;
            else if (duty < regs.backlight_step) duty = '0;
            else duty = duty - regs.backlight_step;
        end
    endfunction

    function void step_up(input bit per_en, input bit duty_en);
        logic [8:0] sum;
        if (per_en) period = (period <= 1) ? 4'(tbda_pkg::PERIOD_MAX_DEF) : period - 4'd1;
        if (duty_en) begin
            sum = {1'b0, duty} + {1'b0, regs.backlight_step};
            if (duty == regs.backlight_period) duty = '0;
            else if (sum > {1'b0, regs.backlight_period}) duty = regs.backlight_period;
            else duty = sum[7:0];
        end
    endfunction

    function void note_tick(input tbda_pkg::in_item_t t);
        bit                  minus_dn;
        bit                  plus_dn;
        bit                  per_en;
        bit                  duty_en;
        bit                  restart;
        tbda_pkg::out_item_t e;
        minus_dn = !t.minus_level;
        plus_dn  = !t.plus_level;
        per_en   = !t.period_enable_n;
        duty_en  = !t.duty_enable_n;
        restart  = 1'b0;
        case (state)
            ST_IDLE: begin
                if (minus_dn) begin
                    restart = 1'b1;
                    state = ST_MINUS_DB;
                end else if (plus_dn) begin
                    restart = 1'b1;
                    state = ST_PLUS_DB;
                end
            end
            ST_MINUS_DB: begin
                if (hold_count >= regs.debounce_ticks)
                    state = minus_dn ? ST_MINUS_ACT : ST_IDLE;
            end
            ST_MINUS_ACT: begin
                step_down(per_en, duty_en);
                state = ST_MINUS_HOLD;
            end
            ST_MINUS_HOLD: begin
                // long press fires before the release is taken
                if (hold_count >= regs.long_press_ticks) begin
                    speaker = 1'b0;
                    restart = 1'b1;
                end
                if (!minus_dn) begin
                    state = ST_RELEASE_DB;
                    restart = 1'b1;
                end
            end
            ST_RELEASE_DB: begin
                if (hold_count >= regs.debounce_ticks) state = ST_IDLE;
            end
            ST_PLUS_DB: begin
                if (hold_count >= regs.debounce_ticks)
                    state = plus_dn ? ST_PLUS_ACT : ST_IDLE;
            end
            ST_PLUS_ACT: begin
                step_up(per_en, duty_en);
                state = ST_PLUS_HOLD;
            end
            default: begin
                if (hold_count >= regs.long_press_ticks) begin
                    speaker = 1'b1;
                    restart = 1'b1;
                end
                if (!plus_dn) begin
                    state = ST_RELEASE_DB;
                    restart = 1'b1;
                end
            end
        endcase
        if (restart) hold_count = '0;
        else if (hold_count != 16'hFFFF) hold_count = hold_count + 16'd1;
        e.audio_period   = period;
        e.backlight_duty = duty;
        e.audio_on       = speaker;
        e.fsm_state      = state;
        expected_settings.push_back(e);
    endfunction

    task check_result(input tbda_pkg::out_item_t got);
        tbda_pkg::out_item_t e;
        if (expected_settings.size() == 0) begin
            report($sformatf("result %h with nothing expected", got));
            return;
        end
        e = expected_settings.pop_front();
        if (got.audio_period !== e.audio_period)
            report($sformatf("audio_period %0d, expected %0d", got.audio_period, e.audio_period));
        if (got.backlight_duty !== e.backlight_duty)
            report($sformatf("backlight_duty %0d, expected %0d",
                             got.backlight_duty, e.backlight_duty));
        if (got.audio_on !== e.audio_on)
            report($sformatf("audio_on %b, expected %b", got.audio_on, e.audio_on));
        if (got.fsm_state !== e.fsm_state)
            report($sformatf("fsm_state %0d, expected %0d", got.fsm_state, e.fsm_state));
    endtask
endclass

module tb_two_button_debounce_adjust_unit;

    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int PHASE_TICKS    = 170;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    tbda_pkg::in_item_t  s_data    = '1;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    tbda_pkg::out_item_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [7:0]          cfg_index = '0;
    logic [15:0]         cfg_data  = '0;

    bit quiet = 1'b0;
    int stall_left = 0;
    int ticks_sent = 0;

    adjust_scoreboard sb;

    two_button_debounce_adjust_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // transfer monitors
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.note_tick(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (quiet || !aresetn) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < 3) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_tick(input tbda_pkg::in_item_t t);
        if (!quiet && $urandom_range(99) < 3) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_regs(input logic [15:0] db, input logic [15:0] lp,
                              input logic [7:0] per, input logic [7:0] step);
        logic [7:0]  idx  [5];
        logic [15:0] vals [5];
        idx[0]  = tbda_pkg::REG_DEBOUNCE;
        idx[1]  = tbda_pkg::REG_LONG_PRESS;
        idx[2]  = tbda_pkg::REG_BL_PERIOD;
        idx[3]  = tbda_pkg::REG_BL_STEP;
        idx[4]  = 8'(tbda_pkg::REG_BL_STEP) + 8'($urandom_range(1, 252));
        vals[0] = db;
        vals[1] = lp;
        vals[2] = {8'($urandom_range(255)), per};
        vals[3] = {8'($urandom_range(255)), step};
        vals[4] = 16'($urandom);
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic tbda_pkg::in_item_t make_tick(input bit use_plus, input bit pressed,
                                                     input bit other_pressed);
        tbda_pkg::in_item_t t;
        t.period_enable_n = ($urandom_range(99) >= 65);
        t.duty_enable_n   = ($urandom_range(99) >= 65);
        t.minus_level     = use_plus ? !other_pressed : !pressed;
        t.plus_level      = use_plus ? !pressed : !other_pressed;
        return t;
    endfunction

    // press with bounce, hold of random length, release; sometimes pure noise
    task automatic press_sequence(input int db, input int lp);
        bit use_plus;
        int hold;
        int rel;
        use_plus = 1'($urandom_range(1));
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 8))
                send_tick(tbda_pkg::in_item_t'(4'($urandom_range(15))));
            return;
        end
        repeat ($urandom_range(0, 3))
            send_tick(make_tick(use_plus, 1'($urandom_range(1)), 1'b0));
        case ($urandom_range(3))
            0: hold = $urandom_range(0, db);
            1: hold = $urandom_range(db, db + lp + 3);
            default: hold = $urandom_range(db + lp, db + 4 * lp + 4);
        endcase
        repeat (hold)
            send_tick(make_tick(use_plus, $urandom_range(49) != 0, $urandom_range(6) == 0));
        rel = $urandom_range(0, db + 3);
        repeat (rel) send_tick(make_tick(use_plus, 1'b0, $urandom_range(19) == 0));
    endtask

    task automatic run_directed();
        // bits: minus, plus, period_enable_n, duty_enable_n
        logic [3:0] seq [20];
        seq = '{4'b1111, 4'b0000, 4'b1111, 4'b1111,
                4'b0100, 4'b0100, 4'b0100, 4'b0100, 4'b1100,
                4'b1111, 4'b1111,
                4'b1000, 4'b1000, 4'b1000, 4'b1000, 4'b1000, 4'b1011,
                4'b1111, 4'b1111, 4'b1111};
        for (int i = 0; i < 20; i++) send_tick(tbda_pkg::in_item_t'(seq[i]));
    endtask

    initial begin
        int phase;
        int db;
        int lp;
        int per;
        int step;
        int start;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults: one minus press past the debounce time, then release
        repeat (150) send_tick(make_tick(1'b0, 1'b1, 1'b0));
        repeat (105) send_tick(make_tick(1'b0, 1'b0, 1'b0));

        settle();
        write_regs(16'd1, 16'd2, 8'd100, 8'd30);
        run_directed();

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin db = 1; lp = 1; per = 255; step = 1; end
                1: begin db = 2; lp = 5; per = 1; step = 1; end
                2: begin db = 3; lp = 8; per = 255; step = 255; end
                3: begin
                    db = $urandom_range(1, 6); lp = $urandom_range(1, 20);
                    per = 7; step = 3;
                end
                4: begin db = 1; lp = 3; per = 50; step = 200; end
                default: begin
                    db = $urandom_range(1, 6); lp = $urandom_range(1, 25);
                    per = $urandom_range(1, 255); step = $urandom_range(1, 255);
                end
            endcase
            settle();
            write_regs(16'(db), 16'(lp), 8'(per), 8'(step));
            quiet = (phase == 0);
            start = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS) press_sequence(db, lp);
        end

        // largest register values: the debounce wait never ends within the press
        settle();
        quiet = 1'b0;
        write_regs(16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
        repeat (60) send_tick(make_tick(1'b0, 1'b1, 1'b0));
        repeat (20) send_tick(make_tick(1'b0, 1'b0, 1'b0));

        settle();
        repeat (4) @(posedge aclk);
        if (sb.pending() != 0) sb.report("expected results never arrived");
        if (sb.errors == 0) begin
            $display("two_button_debounce_adjust_unit test passed");
        end else begin
            $display("two_button_debounce_adjust_unit test failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 8);
        $display("two_button_debounce_adjust_unit test failed");
        $finish;
    end

endmodule
